### hdl/nfbp_pkg.sv
package nfbp_pkg;

   localparam int ADDR_W = 22;
   localparam int BYTE_W = 8;
   localparam int WORD_W = 16;
   localparam int KIND_W = 3;
   localparam int IDX_W  = 3;

   localparam int BUFFER_BYTES_DEF = 32;

   // item kinds
   localparam logic [KIND_W-1:0] KIND_SET_ADDR = 3'd0;
   localparam logic [KIND_W-1:0] KIND_BEGIN    = 3'd1;
   localparam logic [KIND_W-1:0] KIND_WORD     = 3'd2;
   localparam logic [KIND_W-1:0] KIND_COMMIT   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_STATUS   = 3'd4;

   // command bus values
   localparam logic [13:0]       UNLOCK_ADDR_A = 14'h0AAA;
   localparam logic [13:0]       UNLOCK_ADDR_B = 14'h0555;
   localparam logic [BYTE_W-1:0] CMD_UNLOCK_A  = 8'hAA;
   localparam logic [BYTE_W-1:0] CMD_UNLOCK_B  = 8'h55;
   localparam logic [BYTE_W-1:0] CMD_ERASE     = 8'h80;
   localparam logic [BYTE_W-1:0] CMD_SECTOR    = 8'h30;
   localparam logic [BYTE_W-1:0] CMD_BUFFER    = 8'h25;
   localparam logic [BYTE_W-1:0] CMD_CONFIRM   = 8'h29;

   localparam logic EV_WRITE = 1'b0;
   localparam logic EV_DONE  = 1'b1;

   typedef enum logic [2:0] {
      BK_ERASE,
      BK_OPEN,
      BK_DONE_OPEN,
      BK_DATA,
      BK_COMMIT,
      BK_DONE
   } burst_kind_type;

   typedef struct packed {
      logic                valid;
      burst_kind_type      kind;
      logic [ADDR_W-1:0]   base;
      logic [ADDR_W-1:0]   addr0;
      logic [ADDR_W-1:0]   addr1;
      logic [WORD_W-1:0]   word;
   } burst_type;

   function automatic logic [IDX_W-1:0] burst_beats(burst_kind_type kind);
      logic [IDX_W-1:0] n;
      case (kind)
         BK_ERASE:     n = 3'd6;
         BK_OPEN:      n = 3'd4;
         BK_DONE_OPEN: n = 3'd5;
         BK_DATA:      n = 3'd2;
         default:      n = 3'd1;
      endcase
      return n;
   endfunction

endpackage

### hdl/nfbp_ctrl.sv
module nfbp_ctrl import nfbp_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ADDR_W-1:0]   req_address_value,
   input  logic [WORD_W-1:0]   req_word_value,
   input  logic [BYTE_W-1:0]   req_status_byte,
   input  logic                emit_ready,
   output burst_type           burst
);

   localparam int OFF_W = $clog2(BUFFER_BYTES);
   localparam logic [OFF_W:0] BB_CNT = (OFF_W+1)'(BUFFER_BYTES);

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOADING,
      PH_WAITING
   } phase_type;

   logic                item_valid_ff, item_valid_in;
   logic [KIND_W-1:0]   item_kind_ff, item_kind_in;
   logic [ADDR_W-1:0]   item_addr_ff, item_addr_in;
   logic [WORD_W-1:0]   item_word_ff, item_word_in;
   logic [BYTE_W-1:0]   item_status_ff, item_status_in;

   phase_type           phase_ff, phase_in;
   logic [ADDR_W-1:0]   next_addr_ff, next_addr_in;
   logic                pae_ff, pae_in;
   logic [BYTE_W-1:0]   first_poll_ff, first_poll_in;
   logic                poll_half_ff, poll_half_in;
   logic [OFF_W-1:0]    offset_ff, offset_in;

   logic                take;
   logic [OFF_W:0]      off1_sum, off2_sum;
   logic [OFF_W-1:0]    off1, off2;

   assign take      = item_valid_ff & emit_ready;
   assign req_stall = item_valid_ff & ~emit_ready;

   // buffer offsets of a word's second byte and of the next word, wrapping at the buffer size
   always_comb begin
      off1_sum = {1'b0, offset_ff} + (OFF_W+1)'(1);
      off1     = (off1_sum == BB_CNT) ? '0 : off1_sum[OFF_W-1:0];
      off2_sum = {1'b0, off1} + (OFF_W+1)'(1);
      off2     = (off2_sum == BB_CNT) ? '0 : off2_sum[OFF_W-1:0];
   end

   always_comb begin
      item_valid_in  = item_valid_ff;
      item_kind_in   = item_kind_ff;
      item_addr_in   = item_addr_ff;
      item_word_in   = item_word_ff;
      item_status_in = item_status_ff;
      if (req_valid && !req_stall) begin
         item_valid_in  = 1'b1;
         item_kind_in   = req_kind;
         item_addr_in   = req_address_value;
         item_word_in   = req_word_value;
         item_status_in = req_status_byte;
      end else if (take) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      phase_in      = phase_ff;
      next_addr_in  = next_addr_ff;
      pae_in        = pae_ff;
      first_poll_in = first_poll_ff;
      poll_half_in  = poll_half_ff;
      offset_in     = offset_ff;

      burst.valid = 1'b0;
      burst.kind  = BK_DONE;
      burst.base  = next_addr_ff;
      burst.addr0 = {next_addr_ff[ADDR_W-1:7],
                     7'(next_addr_ff[6:0] + 7'(offset_ff))};
      burst.addr1 = {next_addr_ff[ADDR_W-1:7],
                     7'(next_addr_ff[6:0] + 7'(off1))};
      burst.word  = item_word_ff;

      if (take) begin
         case (item_kind_ff)
            KIND_SET_ADDR: begin
               if (phase_ff == PH_IDLE) next_addr_in = item_addr_ff;
            end
            KIND_BEGIN: begin
               if (phase_ff == PH_IDLE) begin
                  burst.valid = 1'b1;
                  if (next_addr_ff[15:0] == 16'd0) begin
                     // sector boundary: erase first, program once it is done
                     burst.kind   = BK_ERASE;
                     pae_in       = 1'b1;
                     phase_in     = PH_WAITING;
                     poll_half_in = 1'b0;
                  end else begin
                     burst.kind = BK_OPEN;
                     offset_in  = '0;
                     phase_in   = PH_LOADING;
                  end
               end
            end
            KIND_WORD: begin
               if (phase_ff == PH_LOADING) begin
                  burst.valid = 1'b1;
                  burst.kind  = BK_DATA;
                  offset_in   = off2;
               end
            end
            KIND_COMMIT: begin
               if (phase_ff == PH_LOADING) begin
                  burst.valid  = 1'b1;
                  burst.kind   = BK_COMMIT;
                  next_addr_in = next_addr_ff + ADDR_W'(BUFFER_BYTES);
                  pae_in       = 1'b0;
                  phase_in     = PH_WAITING;
                  poll_half_in = 1'b0;
               end
            end
            KIND_STATUS: begin
               if (phase_ff == PH_WAITING) begin
                  if (!poll_half_ff) begin
                     first_poll_in = item_status_ff;
                     poll_half_in  = 1'b1;
                  end else begin
                     poll_half_in = 1'b0;
                     // toggle bit has stopped when both reads agree
                     if (first_poll_ff == item_status_ff) begin
                        burst.valid = 1'b1;
                        if (pae_ff) begin
                           burst.kind = BK_DONE_OPEN;
                           pae_in     = 1'b0;
                           offset_in  = '0;
                           phase_in   = PH_LOADING;
                        end else begin
                           burst.kind = BK_DONE;
                           phase_in   = PH_IDLE;
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      item_kind_ff   <= item_kind_in;
      item_addr_ff   <= item_addr_in;
      item_word_ff   <= item_word_in;
      item_status_ff <= item_status_in;
      if (reset) begin
         item_valid_ff <= 1'b0;
         phase_ff      <= PH_IDLE;
         next_addr_ff  <= '0;
         pae_ff        <= 1'b0;
         first_poll_ff <= '0;
         poll_half_ff  <= 1'b0;
         offset_ff     <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         phase_ff      <= phase_in;
         next_addr_ff  <= next_addr_in;
         pae_ff        <= pae_in;
         first_poll_ff <= first_poll_in;
         poll_half_ff  <= poll_half_in;
         offset_ff     <= offset_in;
      end
   end

   a_poll_only_waiting: assert property (@(posedge clock) disable iff (reset)
      poll_half_ff |-> phase_ff == PH_WAITING)
      else $error("poll pair open outside a wait");

   a_pending_only_waiting: assert property (@(posedge clock) disable iff (reset)
      pae_ff |-> phase_ff == PH_WAITING)
      else $error("pending program outside an erase wait");

endmodule

### hdl/nfbp_emit.sv
module nfbp_emit import nfbp_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  burst_type           burst,
   output logic                emit_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_event_res,
   output logic [ADDR_W-1:0]   rsp_cycle_address,
   output logic [BYTE_W-1:0]   rsp_cycle_data,
   output logic                rsp_last
);

   localparam logic [BYTE_W-1:0] COUNT_BYTE = BYTE_W'(BUFFER_BYTES - 1);

   logic                busy_ff, busy_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   burst_type           desc_ff, desc_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_event_ff, rsp_event_in;
   logic [ADDR_W-1:0]   rsp_addr_ff, rsp_addr_in;
   logic [BYTE_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                out_free, last_beat;
   logic [IDX_W-1:0]    open_idx;
   logic [ADDR_W-1:0]   unlock_a, unlock_b;
   logic                beat_event;
   logic [ADDR_W-1:0]   beat_addr;
   logic [BYTE_W-1:0]   beat_data;

   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign last_beat  = (idx_ff == burst_beats(desc_ff.kind) - IDX_W'(1));
   assign emit_ready = ~busy_ff | (out_free & last_beat);

   assign unlock_a = {desc_ff.base[ADDR_W-1:14], UNLOCK_ADDR_A};
   assign unlock_b = {desc_ff.base[ADDR_W-1:14], UNLOCK_ADDR_B};
   assign open_idx = (desc_ff.kind == BK_DONE_OPEN) ? idx_ff - IDX_W'(1) : idx_ff;

   // one bus beat of the current burst
   always_comb begin
      beat_event = EV_WRITE;
      beat_addr  = desc_ff.base;
      beat_data  = CMD_CONFIRM;
      case (desc_ff.kind)
         BK_ERASE: begin
            case (idx_ff)
               3'd0:    begin beat_addr = unlock_a; beat_data = CMD_UNLOCK_A; end
               3'd1:    begin beat_addr = unlock_b; beat_data = CMD_UNLOCK_B; end
               3'd2:    begin beat_addr = unlock_a; beat_data = CMD_ERASE;    end
               3'd3:    begin beat_addr = unlock_a; beat_data = CMD_UNLOCK_A; end
               3'd4:    begin beat_addr = unlock_b; beat_data = CMD_UNLOCK_B; end
               default: begin beat_addr = desc_ff.base; beat_data = CMD_SECTOR; end
            endcase
         end
         BK_OPEN, BK_DONE_OPEN: begin
            if (desc_ff.kind == BK_DONE_OPEN && idx_ff == '0) begin
               beat_event = EV_DONE;
               beat_addr  = '0;
               beat_data  = '0;
            end else begin
               case (open_idx)
                  3'd0:    begin beat_addr = unlock_a; beat_data = CMD_UNLOCK_A; end
                  3'd1:    begin beat_addr = unlock_b; beat_data = CMD_UNLOCK_B; end
                  3'd2:    begin beat_addr = desc_ff.base; beat_data = CMD_BUFFER; end
                  default: begin beat_addr = desc_ff.base; beat_data = COUNT_BYTE; end
               endcase
            end
         end
         BK_DATA: begin
            // high byte first
            if (idx_ff == '0) begin
               beat_addr = desc_ff.addr0;
               beat_data = desc_ff.word[WORD_W-1:BYTE_W];
            end else begin
               beat_addr = desc_ff.addr1;
               beat_data = desc_ff.word[BYTE_W-1:0];
            end
         end
         BK_COMMIT: begin
            beat_addr = desc_ff.base;
            beat_data = CMD_CONFIRM;
         end
         default: begin
            beat_event = EV_DONE;
            beat_addr  = '0;
            beat_data  = '0;
         end
      endcase
   end

   always_comb begin
      busy_in      = busy_ff;
      idx_in       = idx_ff;
      desc_in      = desc_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_event_in = rsp_event_ff;
      rsp_addr_in  = rsp_addr_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (out_free) begin
         rsp_valid_in = busy_ff;
         if (busy_ff) begin
            rsp_event_in = beat_event;
            rsp_addr_in  = beat_addr;
            rsp_data_in  = beat_data;
            rsp_last_in  = last_beat;
            idx_in       = idx_ff + IDX_W'(1);
            if (last_beat) busy_in = 1'b0;
         end
      end
      if (burst.valid) begin
         busy_in = 1'b1;
         idx_in  = '0;
         desc_in = burst;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      desc_ff      <= desc_in;
      rsp_event_ff <= rsp_event_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_event_res     = rsp_event_ff;
   assign rsp_cycle_address = rsp_addr_ff;
   assign rsp_cycle_data    = rsp_data_ff;
   assign rsp_last          = rsp_last_ff;

   a_idx_in_burst: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> idx_ff < burst_beats(desc_ff.kind))
      else $error("beat index beyond burst length");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      burst.valid |-> !busy_ff || (out_free && last_beat))
      else $error("new burst loaded over a running one");

   a_done_is_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_event_ff |-> rsp_addr_ff == '0 && rsp_data_ff == '0)
      else $error("completion beat carries bus data");

endmodule

### hdl/nor_flash_buffer_program_sequencer.sv
// Buffer-program sequencer for a parallel 8-bit NOR flash. Items on the req
// channel set the byte address, begin a buffer program, supply 16-bit data
// words, commit the buffer, or hand back status bytes read from the flash while
// an erase or program runs. Each item turns into zero to six beats on the rsp
// channel: a bus write (event_res 0, address and data byte) or a completion
// (event_res 1, address and data zero); rsp_last marks an item's final beat.
// Items that do not fit the current phase, and unknown kinds, give no beats.
// Begin on a 64 KB boundary erases the sector first and resumes the program
// when the toggle bit settles. Timing: the rsp register moves one beat per
// clock while rsp_stall stays low; a data word gives 2 beats, begin 4 or 6,
// commit 1, the final status read of an erase wait 5. The next item is decoded
// in the cycle of the previous item's last beat, so there are no bubbles
// between items while rsp_stall stays low.
module nor_flash_buffer_program_sequencer import nfbp_pkg::*; #(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEF
) (
   input  logic                clock,
   input  logic                reset,
   // request beats
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [KIND_W-1:0]   req_kind,
   input  logic [ADDR_W-1:0]   req_address_value,
   input  logic [WORD_W-1:0]   req_word_value,
   input  logic [BYTE_W-1:0]   req_status_byte,
   // result beats
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_event_res,
   output logic [ADDR_W-1:0]   rsp_cycle_address,
   output logic [BYTE_W-1:0]   rsp_cycle_data,
   output logic                rsp_last
);

   // burst handed from the decoder to the beat generator
   burst_type burst;
   logic      emit_ready;

   // input register, phase tracking, address and buffer offset
   nfbp_ctrl #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_kind          (req_kind),
      .req_address_value (req_address_value),
      .req_word_value    (req_word_value),
      .req_status_byte   (req_status_byte),
      .emit_ready        (emit_ready),
      .burst             (burst)
   );

   // walks a burst one beat per clock into the result register while rsp_stall is low
   nfbp_emit #(
      .BUFFER_BYTES (BUFFER_BYTES)
   ) u_emit (
      .clock             (clock),
      .reset             (reset),
      .burst             (burst),
      .emit_ready        (emit_ready),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_event_res     (rsp_event_res),
      .rsp_cycle_address (rsp_cycle_address),
      .rsp_cycle_data    (rsp_cycle_data),
      .rsp_last          (rsp_last)
   );

endmodule
